FILE: rtl/g2a_pkg.sv
// ----------------------------------------------------------------------------
// g2a_pkg
// shared types and byte constants of the glyph to ansi/utf-8 encoder
// ----------------------------------------------------------------------------
package g2a_pkg;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChFour  = 8'h34;
  localparam logic [7:0] ChEight = 8'h38;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChM     = 8'h6D;

  // sgr digit per attribute flag, bold first
  localparam logic [4:0][7:0] AttrDigit = {8'h37, 8'h35, 8'h34, 8'h33, 8'h31};

  localparam logic [7:0]  Utf2Lead  = 8'hC0;
  localparam logic [7:0]  Utf3Lead  = 8'hE0;
  localparam logic [7:0]  Utf4Lead  = 8'hF0;
  localparam logic [7:0]  UtfCont   = 8'h80;
  localparam logic [20:0] Utf2Limit = 21'h80;
  localparam logic [20:0] Utf3Limit = 21'h800;
  localparam logic [20:0] Utf4Limit = 21'h10000;

  // dig[0] hundreds, dig[1] tens, dig[2] ones
  typedef struct packed {
    logic [2:0][3:0] dig;
    logic [1:0]      ndig;
  } dec_t;

  // val[0..2] foreground rgb, val[3..5] background rgb
  typedef struct packed {
    logic [4:0]      attr;
    dec_t [5:0]      val;
    logic [3:0][7:0] utf;
    logic [1:0]      ulen;
  } glyph_desc_t;

endpackage

FILE: rtl/g2a_if.sv
// ----------------------------------------------------------------------------
// g2a_if
// glyph input channel and byte output channel
// ----------------------------------------------------------------------------
interface g2a_glyph_if;
  logic        valid;
  logic        ready;
  logic [20:0] codepoint;
  logic        bold;
  logic        italic;
  logic        underline;
  logic        blink;
  logic        inverse;
  logic [7:0]  fg_red;
  logic [7:0]  fg_green;
  logic [7:0]  fg_blue;
  logic [7:0]  bg_red;
  logic [7:0]  bg_green;
  logic [7:0]  bg_blue;

  modport source (
    output valid, codepoint, bold, italic, underline, blink, inverse,
           fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
    input  ready
  );
  modport sink (
    input  valid, codepoint, bold, italic, underline, blink, inverse,
           fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
    output ready
  );
endinterface

interface g2a_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

FILE: rtl/glyph_to_ansi_utf8_encoder.sv
// ----------------------------------------------------------------------------
// glyph_to_ansi_utf8_encoder
// glyph to sgr truecolor escape sequences plus utf-8 bytes
//
//   channel  dir  modport          payload
//   glyph_i  in   g2a_glyph_if     codepoint, attribute flags, fg/bg rgb
//   byte_o   out  g2a_byte_if      out_byte, last_byte
//
// one byte per cycle on byte_o, 31 to 56 bytes per glyph, set by the flags,
// the decimal widths of the colors and the utf-8 length
// glyphs are taken while the two-entry descriptor queue has room
// first byte of a glyph passes through the descriptor queue, then the output register
// asynchronous active-low reset empties the queue and the output register
// a stall on byte_o holds the sequencer; glyph_i stalls only when the queue fills
// ----------------------------------------------------------------------------
module glyph_to_ansi_utf8_encoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  g2a_glyph_if.sink     glyph_i,
  g2a_byte_if.source    byte_o
);

  logic                  push;
  logic                  pop;
  logic                  q_full;
  logic                  q_valid;
  g2a_pkg::glyph_desc_t  desc_in;
  g2a_pkg::glyph_desc_t  desc_head;

  g2a_front u_front (
    .glyph_i  (glyph_i),
    .q_full_i (q_full),
    .push_o   (push),
    .desc_o   (desc_in)
  );

  g2a_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .desc_o  (desc_head)
  );

  g2a_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .desc_i    (desc_head),
    .pop_o     (pop),
    .byte_o    (byte_o)
  );

endmodule

FILE: rtl/g2a_front.sv
// ----------------------------------------------------------------------------
// g2a_front
// accepts a glyph, splits colors into decimal digits and builds utf-8 bytes
// ----------------------------------------------------------------------------
module g2a_front (
  g2a_glyph_if.sink             glyph_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output g2a_pkg::glyph_desc_t  desc_o
);

  function automatic g2a_pkg::dec_t to_dec(input logic [7:0] v);
    g2a_pkg::dec_t res;
    logic [1:0]    h;
    logic [6:0]    r;
    logic [14:0]   p;
    logic [3:0]    t;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = 7'(v - 8'(h) * 8'd100);
    p = 15'(r) * 15'd205;
    t = 4'(p >> 11);
    res.dig[0] = {2'b00, h};
    res.dig[1] = t;
    res.dig[2] = 4'(r - 7'(t) * 7'd10);
    res.ndig   = (v >= 8'd100) ? 2'd3 : ((v >= 8'd10) ? 2'd2 : 2'd1);
    return res;
  endfunction

  logic [20:0] cp;

  assign glyph_i.ready = !q_full_i;
  assign push_o        = glyph_i.valid && !q_full_i;
  assign cp            = glyph_i.codepoint;

  always_comb begin
    desc_o.attr   = {glyph_i.inverse, glyph_i.blink, glyph_i.underline,
                     glyph_i.italic, glyph_i.bold};
    desc_o.val[0] = to_dec(glyph_i.fg_red);
    desc_o.val[1] = to_dec(glyph_i.fg_green);
    desc_o.val[2] = to_dec(glyph_i.fg_blue);
    desc_o.val[3] = to_dec(glyph_i.bg_red);
    desc_o.val[4] = to_dec(glyph_i.bg_green);
    desc_o.val[5] = to_dec(glyph_i.bg_blue);
    desc_o.utf    = '0;
    priority if (cp < g2a_pkg::Utf2Limit) begin
      desc_o.utf[0] = cp[7:0];
      desc_o.ulen   = 2'd0;
    end else if (cp < g2a_pkg::Utf3Limit) begin
      desc_o.utf[0] = g2a_pkg::Utf2Lead | {3'b000, cp[10:6]};
      desc_o.utf[1] = g2a_pkg::UtfCont | {2'b00, cp[5:0]};
      desc_o.ulen   = 2'd1;
    end else if (cp < g2a_pkg::Utf4Limit) begin
      desc_o.utf[0] = g2a_pkg::Utf3Lead | {4'b0000, cp[15:12]};
      desc_o.utf[1] = g2a_pkg::UtfCont | {2'b00, cp[11:6]};
      desc_o.utf[2] = g2a_pkg::UtfCont | {2'b00, cp[5:0]};
      desc_o.ulen   = 2'd2;
    end else begin
      desc_o.utf[0] = g2a_pkg::Utf4Lead | {5'b00000, cp[20:18]};
      desc_o.utf[1] = g2a_pkg::UtfCont | {2'b00, cp[17:12]};
      desc_o.utf[2] = g2a_pkg::UtfCont | {2'b00, cp[11:6]};
      desc_o.utf[3] = g2a_pkg::UtfCont | {2'b00, cp[5:0]};
      desc_o.ulen   = 2'd3;
    end
  end

endmodule

FILE: rtl/g2a_queue.sv
// ----------------------------------------------------------------------------
// g2a_queue
// short fifo of glyph descriptors between front and back
// ----------------------------------------------------------------------------
module g2a_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  g2a_pkg::glyph_desc_t  desc_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output g2a_pkg::glyph_desc_t  desc_o
);

  localparam int PtrW = g2a_pkg::QPtrW;

  g2a_pkg::glyph_desc_t     mem_q [g2a_pkg::QueueDepth];
  logic [PtrW-1:0]          wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]          rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]            cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(g2a_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign desc_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(g2a_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(g2a_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

FILE: rtl/g2a_back.sv
// ----------------------------------------------------------------------------
// g2a_back
// byte sequencer: walks sgr, color and utf-8 segments, one byte per transfer
// ----------------------------------------------------------------------------
module g2a_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  g2a_pkg::glyph_desc_t  desc_i,
  output logic                  pop_o,
  g2a_byte_if.source            byte_o
);

  typedef enum logic [2:0] {
    StHead, StAttr, StM, StColor, StVal, StSep, StCEnd, StUtf
  } state_e;

  state_e      state_q, state_d;
  logic [2:0]  pos_q, pos_d;
  logic        color_q, color_d;
  logic [1:0]  comp_q, comp_d;
  logic [4:0]  attr_left_q, attr_left_d;
  logic        out_valid_q;
  logic [7:0]  out_byte_q, byte_d;
  logic        out_last_q, last_d;
  logic        advance;
  logic [2:0]  vidx, first_idx;
  logic [2:0]  lo_idx;
  logic [4:0]  lo_bit;

  assign advance         = q_valid_i && (!out_valid_q || byte_o.ready);
  assign byte_o.valid    = out_valid_q;
  assign byte_o.out_byte = out_byte_q;
  assign byte_o.last_byte = out_last_q;

  assign vidx      = color_q ? 3'(comp_q) + 3'd3 : 3'(comp_q);
  assign first_idx = color_q ? 3'd3 : 3'd0;

  // lowest attribute flag still to be sent
  always_comb begin
    priority if (attr_left_q[0]) begin
      lo_idx = 3'd0;
    end else if (attr_left_q[1]) begin
      lo_idx = 3'd1;
    end else if (attr_left_q[2]) begin
      lo_idx = 3'd2;
    end else if (attr_left_q[3]) begin
      lo_idx = 3'd3;
    end else begin
      lo_idx = 3'd4;
    end
    lo_bit = 5'd1 << lo_idx;
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    color_d     = color_q;
    comp_d      = comp_q;
    attr_left_d = attr_left_q;
    byte_d      = g2a_pkg::ChEsc;
    last_d      = 1'b0;
    pop_o       = 1'b0;
    unique case (state_q)
      StHead: begin
        unique case (pos_q)
          3'd0:    byte_d = g2a_pkg::ChEsc;
          3'd1:    byte_d = g2a_pkg::ChLbr;
          default: byte_d = g2a_pkg::ChZero;
        endcase
        pos_d = pos_q + 3'd1;
        if (pos_q >= 3'd2) begin
          pos_d       = '0;
          attr_left_d = desc_i.attr;
          state_d     = (desc_i.attr != '0) ? StAttr : StM;
        end
      end
      StAttr: begin
        if (!pos_q[0]) begin
          byte_d = g2a_pkg::ChSemi;
          pos_d  = 3'd1;
        end else begin
          byte_d      = g2a_pkg::AttrDigit[lo_idx];
          attr_left_d = attr_left_q & ~lo_bit;
          pos_d       = '0;
          if ((attr_left_q & ~lo_bit) == '0) begin
            state_d = StM;
          end
        end
      end
      StM: begin
        byte_d  = g2a_pkg::ChM;
        color_d = 1'b0;
        pos_d   = '0;
        state_d = StColor;
      end
      StColor: begin
        unique case (pos_q)
          3'd0:    byte_d = g2a_pkg::ChEsc;
          3'd1:    byte_d = g2a_pkg::ChLbr;
          3'd2:    byte_d = color_q ? g2a_pkg::ChFour : g2a_pkg::ChThree;
          3'd3:    byte_d = g2a_pkg::ChEight;
          3'd5:    byte_d = g2a_pkg::ChTwo;
          default: byte_d = g2a_pkg::ChSemi;
        endcase
        pos_d = pos_q + 3'd1;
        if (pos_q >= 3'd6) begin
          comp_d  = '0;
          pos_d   = 3'd3 - 3'(desc_i.val[first_idx].ndig);
          state_d = StVal;
        end
      end
      StVal: begin
        byte_d = g2a_pkg::ChZero | {4'b0000, desc_i.val[vidx].dig[pos_q[1:0]]};
        pos_d  = pos_q + 3'd1;
        if (pos_q >= 3'd2) begin
          state_d = (comp_q == 2'd2) ? StCEnd : StSep;
        end
      end
      StSep: begin
        byte_d  = g2a_pkg::ChSemi;
        comp_d  = comp_q + 2'd1;
        pos_d   = 3'd3 - 3'(desc_i.val[vidx + 3'd1].ndig);
        state_d = StVal;
      end
      StCEnd: begin
        byte_d = g2a_pkg::ChM;
        pos_d  = '0;
        if (!color_q) begin
          color_d = 1'b1;
          state_d = StColor;
        end else begin
          state_d = StUtf;
        end
      end
      StUtf: begin
        byte_d = desc_i.utf[pos_q[1:0]];
        pos_d  = pos_q + 3'd1;
        if (pos_q[1:0] == desc_i.ulen) begin
          last_d  = 1'b1;
          pop_o   = advance;
          pos_d   = '0;
          color_d = 1'b0;
          state_d = StHead;
        end
      end
      default: begin
        state_d = StHead;
        pos_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StHead;
      pos_q       <= '0;
      color_q     <= 1'b0;
      comp_q      <= '0;
      attr_left_q <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (byte_o.ready || !out_valid_q) begin
        out_valid_q <= q_valid_i;
      end
      if (advance) begin
        state_q     <= state_d;
        pos_q       <= pos_d;
        color_q     <= color_d;
        comp_q      <= comp_d;
        attr_left_q <= attr_left_d;
        out_byte_q  <= byte_d;
        out_last_q  <= last_d;
      end
    end
  end

  a_pop_in_utf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == StUtf))
    else $error("descriptor popped outside utf-8 segment");

  a_head_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q == StHead && pos_q == 3'd0) |=> (out_byte_q == g2a_pkg::ChEsc))
    else $error("glyph stream does not open with escape");

  a_attr_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAttr) |-> (attr_left_q != '0))
    else $error("attribute segment with no flag left");

  a_val_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StVal) |-> (pos_q <= 3'd2))
    else $error("digit index out of range");

  a_last_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && out_last_q))
    else $error("pop without last byte");

endmodule

FILE: dv/g2a_tb_pkg.sv
// ----------------------------------------------------------------------------
// g2a_tb_pkg
// glyph type and byte-stream scoreboard for the glyph to ansi/utf-8 encoder
//
// each accepted glyph is expanded into the bytes the encoder must send: the
// attribute sgr, the foreground and background truecolor sgr and the utf-8
// form. every byte transfer on the output is checked in order against the
// oldest expected byte, data and last flag separately
// ----------------------------------------------------------------------------
package g2a_tb_pkg;

  // attr[0] bold, [1] italic, [2] underline, [3] blink, [4] inverse
  typedef struct packed {
    logic [20:0] codepoint;
    logic [4:0]  attr;
    logic [7:0]  fg_red;
    logic [7:0]  fg_green;
    logic [7:0]  fg_blue;
    logic [7:0]  bg_red;
    logic [7:0]  bg_green;
    logic [7:0]  bg_blue;
  } glyph_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  localparam logic [7:0] EscChar  = 8'h1B;
  localparam logic [7:0] ZeroChar = 8'h30;
  localparam logic [7:0] FgCode   = 8'd38;
  localparam logic [7:0] BgCode   = 8'd48;
  localparam logic [7:0] Lead2    = 8'hC0;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;
  localparam int         MaxPrinted = 30;

  class sgr_stream_board;
    stream_byte_t expected_bytes[$];
    int unsigned  mismatches;
    int unsigned  bytes_checked;
    int unsigned  glyphs_noted;
    int unsigned  utf_len_count[1:4];
    int unsigned  attr_count[0:4];

    function new();
      mismatches    = 0;
      bytes_checked = 0;
      glyphs_noted  = 0;
      for (int i = 1; i <= 4; i++) utf_len_count[i] = 0;
      for (int i = 0; i <= 4; i++) attr_count[i] = 0;
    endfunction

    function void push(logic [7:0] data, logic last);
      stream_byte_t item;
      item.data = data;
      item.last = last;
      expected_bytes.insert(expected_bytes.size(), item);
    endfunction

    function void push_decimal(logic [7:0] level);
      int unsigned n;
      logic [7:0]  digit;
      n = {24'd0, level};
      if (n >= 100) begin
        digit = ZeroChar + 8'(n / 100);
        push(digit, 1'b0);
      end
      if (n >= 10) begin
        digit = ZeroChar + 8'((n / 10) % 10);
        push(digit, 1'b0);
      end
      digit = ZeroChar + 8'(n % 10);
      push(digit, 1'b0);
    endfunction

    function void push_color(logic [7:0] code, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b);
      push(EscChar, 1'b0);
      push("[", 1'b0);
      push_decimal(code);
      push(";", 1'b0);
      push("2", 1'b0);
      push(";", 1'b0);
      push_decimal(r);
      push(";", 1'b0);
      push_decimal(g);
      push(";", 1'b0);
      push_decimal(b);
      push("m", 1'b0);
    endfunction

    function void add_glyph(glyph_t g);
      logic [7:0] attr_digit[0:4];
      logic [20:0] cp;
      attr_digit[0] = "1";
      attr_digit[1] = "3";
      attr_digit[2] = "4";
      attr_digit[3] = "5";
      attr_digit[4] = "7";
      cp = g.codepoint;
      glyphs_noted++;

      push(EscChar, 1'b0);
      push("[", 1'b0);
      push("0", 1'b0);
      for (int i = 0; i < 5; i++) begin
        if (g.attr[i]) begin
          attr_count[i]++;
          push(";", 1'b0);
          push(attr_digit[i], 1'b0);
        end
      end
      push("m", 1'b0);

      push_color(FgCode, g.fg_red, g.fg_green, g.fg_blue);
      push_color(BgCode, g.bg_red, g.bg_green, g.bg_blue);

      if (cp < 21'h80) begin
        utf_len_count[1]++;
        push(cp[7:0], 1'b1);
      end else if (cp < 21'h800) begin
        utf_len_count[2]++;
        push(Lead2 | {3'b000, cp[10:6]}, 1'b0);
        push(ContMark | {2'b00, cp[5:0]}, 1'b1);
      end else if (cp < 21'h10000) begin
        utf_len_count[3]++;
        push(Lead3 | {4'b0000, cp[15:12]}, 1'b0);
        push(ContMark | {2'b00, cp[11:6]}, 1'b0);
        push(ContMark | {2'b00, cp[5:0]}, 1'b1);
      end else begin
        utf_len_count[4]++;
        push(Lead4 | {5'b00000, cp[20:18]}, 1'b0);
        push(ContMark | {2'b00, cp[17:12]}, 1'b0);
        push(ContMark | {2'b00, cp[11:6]}, 1'b0);
        push(ContMark | {2'b00, cp[5:0]}, 1'b1);
      end
    endfunction

    task report(string msg);
      if (mismatches < MaxPrinted) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_byte(logic [7:0] data, logic last);
      stream_byte_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte %02h last %b with nothing expected", data, last));
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        report($sformatf("byte %0d: out_byte %02h, expected %02h",
                         bytes_checked, data, want.data));
      end
      if (last !== want.last) begin
        report($sformatf("byte %0d: last_byte %b, expected %b",
                         bytes_checked, last, want.last));
      end
      bytes_checked++;
    endtask
  endclass

endpackage

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// top-level testbench of the glyph to ansi/utf-8 encoder
//
// a directed set of glyphs hits every utf-8 length boundary, unchecked code
// points, each attribute alone and all together, and decimal width edges of
// the color values; then random glyphs follow. the sender works in bursts,
// the receiver stalls in changing patterns and once holds off long enough
// to back the encoder up into its glyph input
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomGlyphs  = 100;
  localparam int LongHold      = 300;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 20;

  typedef enum logic [1:0] {
    RxFull,
    RxBusy,
    RxEveryThird,
    RxStarved
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  g2a_glyph_if glyph_if ();
  g2a_byte_if  byte_if ();

  glyph_to_ansi_utf8_encoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .glyph_i (glyph_if),
    .byte_o  (byte_if)
  );

  g2a_tb_pkg::sgr_stream_board board;

  int          long_hold;
  int          burst_left;
  int unsigned idle_cycles;
  int unsigned input_stall_cycles;
  rx_mode_e    rx_mode;
  int          rx_phase_left;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic g2a_tb_pkg::glyph_t make_glyph(logic [20:0] cp, logic [4:0] attr,
                                                    logic [23:0] fg, logic [23:0] bg);
    g2a_tb_pkg::glyph_t g;
    g.codepoint = cp;
    g.attr      = attr;
    {g.fg_red, g.fg_green, g.fg_blue} = fg;
    {g.bg_red, g.bg_green, g.bg_blue} = bg;
    return g;
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 9));
      1:       return 8'($urandom_range(10, 99));
      2:       return 8'($urandom_range(100, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic g2a_tb_pkg::glyph_t random_glyph();
    g2a_tb_pkg::glyph_t g;
    case ($urandom_range(0, 4))
      0:       g.codepoint = 21'($urandom_range(0, 21'h7F));
      1:       g.codepoint = 21'($urandom_range(21'h80, 21'h7FF));
      2:       g.codepoint = 21'($urandom_range(21'h800, 21'hFFFF));
      3:       g.codepoint = 21'($urandom_range(21'h10000, 21'h10FFFF));
      default: g.codepoint = 21'($urandom_range(0, 21'h1FFFFF));
    endcase
    g.attr     = 5'($urandom_range(0, 31));
    g.fg_red   = random_level();
    g.fg_green = random_level();
    g.fg_blue  = random_level();
    g.bg_red   = random_level();
    g.bg_green = random_level();
    g.bg_blue  = random_level();
    return g;
  endfunction

  // called at a rising edge, returns at the edge of the transfer
  task automatic send_glyph(g2a_tb_pkg::glyph_t g);
    int gap;
    if (burst_left == 0) begin
      glyph_if.valid <= 1'b0;
      gap = $urandom_range(1, 20);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(1, 6);
    end
    burst_left--;
    glyph_if.valid     <= 1'b1;
    glyph_if.codepoint <= g.codepoint;
    glyph_if.bold      <= g.attr[0];
    glyph_if.italic    <= g.attr[1];
    glyph_if.underline <= g.attr[2];
    glyph_if.blink     <= g.attr[3];
    glyph_if.inverse   <= g.attr[4];
    glyph_if.fg_red    <= g.fg_red;
    glyph_if.fg_green  <= g.fg_green;
    glyph_if.fg_blue   <= g.fg_blue;
    glyph_if.bg_red    <= g.bg_red;
    glyph_if.bg_green  <= g.bg_green;
    glyph_if.bg_blue   <= g.bg_blue;
    do @(posedge clk_i); while (glyph_if.ready !== 1'b1);
    board.add_glyph(g);
  endtask

  // receiver
  initial begin
    byte_if.ready = 1'b0;
    rx_phase_left = 0;
    rx_mode       = RxFull;
    forever begin
      @(posedge clk_i);
      if (rx_phase_left == 0) begin
        rx_mode       = rx_mode_e'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(50, 300);
      end
      rx_phase_left--;
      if (long_hold > 0) begin
        long_hold--;
        byte_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RxFull:       byte_if.ready <= 1'b1;
          RxBusy:       byte_if.ready <= ($urandom_range(0, 3) != 0);
          RxEveryThird: byte_if.ready <= (rx_phase_left % 3 == 0);
          default:      byte_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
      board.check_byte(byte_if.out_byte, byte_if.last_byte);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (glyph_if.valid === 1'b1 && glyph_if.ready !== 1'b1) input_stall_cycles++;
    if ((glyph_if.valid === 1'b1 && glyph_if.ready === 1'b1) ||
        (byte_if.valid === 1'b1 && byte_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no transfer for %0d cycles", WatchdogLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    board              = new();
    long_hold          = 0;
    burst_left         = 0;
    idle_cycles        = 0;
    input_stall_cycles = 0;
    rst_ni             = 1'b0;
    glyph_if.valid     = 1'b0;
    glyph_if.codepoint = '0;
    glyph_if.bold      = 1'b0;
    glyph_if.italic    = 1'b0;
    glyph_if.underline = 1'b0;
    glyph_if.blink     = 1'b0;
    glyph_if.inverse   = 1'b0;
    glyph_if.fg_red    = '0;
    glyph_if.fg_green  = '0;
    glyph_if.fg_blue   = '0;
    glyph_if.bg_red    = '0;
    glyph_if.bg_green  = '0;
    glyph_if.bg_blue   = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // utf-8 boundaries, unchecked code points, single and all attributes
    send_glyph(make_glyph(21'h000000, 5'h00, 24'h000000, 24'h000000));
    send_glyph(make_glyph(21'h00007F, 5'h1F, 24'hFFFFFF, 24'hFFFFFF));
    send_glyph(make_glyph(21'h000080, 5'h01, {8'd9, 8'd10, 8'd99},
                          {8'd100, 8'd199, 8'd255}));
    send_glyph(make_glyph(21'h0007FF, 5'h02, {8'd1, 8'd0, 8'd250},
                          {8'd20, 8'd5, 8'd200}));
    send_glyph(make_glyph(21'h000800, 5'h04, {8'd128, 8'd64, 8'd32},
                          {8'd16, 8'd8, 8'd4}));
    send_glyph(make_glyph(21'h00FFFF, 5'h08, {8'd101, 8'd110, 8'd11},
                          {8'd90, 8'd109, 8'd2}));
    send_glyph(make_glyph(21'h010000, 5'h10, {8'd255, 8'd0, 8'd255},
                          {8'd0, 8'd255, 8'd0}));
    send_glyph(make_glyph(21'h10FFFF, 5'h00, {8'd37, 8'd199, 8'd7},
                          {8'd99, 8'd100, 8'd10}));
    send_glyph(make_glyph(21'h00D800, 5'h15, {8'd3, 8'd33, 8'd133},
                          {8'd222, 8'd22, 8'd2}));
    send_glyph(make_glyph(21'h00DFFF, 5'h0A, {8'd19, 8'd91, 8'd190},
                          {8'd250, 8'd5, 8'd55}));
    send_glyph(make_glyph(21'h110000, 5'h1B, {8'd200, 8'd100, 8'd0},
                          {8'd1, 8'd10, 8'd100}));
    send_glyph(make_glyph(21'h1FFFFF, 5'h1F, {8'd0, 8'd9, 8'd255},
                          {8'd254, 8'd99, 8'd1}));
    send_glyph(make_glyph(21'h000041, 5'h0E, {8'd170, 8'd85, 8'd42},
                          {8'd21, 8'd240, 8'd15}));

    // long receiver hold-off while glyphs keep coming
    long_hold = LongHold;
    for (int i = 0; i < RandomGlyphs; i++) send_glyph(random_glyph());
    glyph_if.valid <= 1'b0;

    while (board.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d glyphs, %0d bytes; utf-8 lengths 1/2/3/4: %0d/%0d/%0d/%0d",
             board.glyphs_noted, board.bytes_checked, board.utf_len_count[1],
             board.utf_len_count[2], board.utf_len_count[3], board.utf_len_count[4]);
    $display("one %0d-cycle output hold-off, glyph input stalled %0d cycles, %0d mismatches",
             LongHold, input_stall_cycles, board.mismatches);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/g2a_pkg.sv
rtl/g2a_if.sv
rtl/g2a_front.sv
rtl/g2a_queue.sv
rtl/g2a_back.sv
rtl/glyph_to_ansi_utf8_encoder.sv
dv/g2a_tb_pkg.sv
dv/tb.sv
